FILE: hdl/ffca_pkg.sv
// Shared types and constants for the first-fit contiguous allocator.
package ffca_pkg;

  localparam int WORD_W  = 32;
  localparam int WORD_AW = 5;
  localparam int CNT_W   = 11;
  localparam int SLOT_W  = 10;
  localparam int REJ_W   = 16;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [WORD_AW-1:0] woff_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_FREE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic  found;
    woff_t offset;
    cnt_t  carry;
  } scan_res_t;

  typedef struct packed {
    logic  set;
    woff_t lo;
    woff_t hi;
  } wr_ctl_t;

endpackage

FILE: hdl/ffca_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffca_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/ffca_word_unit.sv
// Shared word unit: free-run search over one map word and range write masking.
module ffca_word_unit
  import ffca_pkg::*;
(
  input  word_t                word,
  input  logic [WORD_AW:0]     nvalid,
  input  cnt_t                 carry,
  input  cnt_t                 count,
  input  wr_ctl_t              wctl,
  output scan_res_t            res,
  output word_t                wdata
);

  word_t             eff;
  word_t             upto;
  word_t             win;
  word_t             mask;
  logic [WORD_W-1:0] ok;
  woff_t             top;
  logic [CNT_W:0]    carry_sum;

  always_comb begin
    // slots at or past the usable limit count as taken
    eff = word | ~({WORD_W{1'b1}} >> (WORD_W - int'(nvalid)));
    upto = '0;
    win = '0;
    for (int i = 0; i < WORD_W; i++) begin
      upto = {WORD_W{1'b1}} >> (WORD_W - 1 - i);
      if (count <= CNT_W'(i + 1)) begin
        win = upto & ({WORD_W{1'b1}} << (i + 1 - int'(count)));
        ok[i] = ~|(eff & win);
      end else begin
        ok[i] = (~|(eff & upto)) &&
                (({1'b0, carry} + (CNT_W+1)'(i + 1)) >= {1'b0, count});
      end
    end

    res.found = |ok;
    res.offset = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (ok[i]) begin
        res.offset = woff_t'(i);
      end
    end

    top = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (eff[i]) begin
        top = woff_t'(i);
      end
    end
    carry_sum = {1'b0, carry} + (CNT_W+1)'(WORD_W);
    if (|eff) begin
      res.carry = CNT_W'(woff_t'(WORD_W - 1) - top);
    end else if (carry_sum[CNT_W]) begin
      res.carry = '1;
    end else begin
      res.carry = carry_sum[CNT_W-1:0];
    end

    mask = ({WORD_W{1'b1}} << wctl.lo) &
           ({WORD_W{1'b1}} >> (woff_t'(WORD_W - 1) - wctl.hi));
    wdata = wctl.set ? (word | mask) : (word & ~mask);
  end

endmodule

FILE: hdl/first_fit_contiguous_allocator_core.sv
// Top level of the first-fit contiguous allocator: sequencer, map RAM, output register.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall  | operation, count, first_slot, last_slot
//  out     | output    | out_valid / out_stall| granted, start_slot, rejected_total
//  cfg     | input     | cfg_valid / cfg_ready| slots_in_use
//
// Allocate: one map word (32 slots) per cycle is scanned, then the granted words are
// rewritten one per cycle. Release rewrites the covered words one per cycle. Zero or
// oversize counts go straight to the result without touching the map.
// After reset a clearing pass zeroes every map word before the first word is taken.
// A finished word waits in the output register while the next item is accepted.
module first_fit_contiguous_allocator_core
  import ffca_pkg::*;
#(
  parameter int SLOTS = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_operation,
  input  logic [CNT_W-1:0]  in_count,
  input  logic [SLOT_W-1:0] in_first_slot,
  input  logic [SLOT_W-1:0] in_last_slot,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_granted,
  output logic [SLOT_W-1:0] out_start_slot,
  output logic [REJ_W-1:0]  out_rejected_total,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_slots_in_use
);

  localparam int DEPTH = (SLOTS + WORD_W - 1) / WORD_W;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = AW + WORD_AW;
  localparam int LIM_W = ($clog2(SLOTS + 1) > CNT_W) ? $clog2(SLOTS + 1) : CNT_W;
  localparam int XW    = ((PW > CNT_W) ? PW : CNT_W) + 1;

  state_t            state_r, state_nxt;
  cnt_t              cfg_r;
  logic [REJ_W-1:0]  rej_r, rej_nxt;
  cnt_t              cnt_r, cnt_nxt;
  logic [AW:0]       rd_addr_r, rd_addr_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     pend_addr_r, pend_addr_nxt;
  cnt_t              carry_r, carry_nxt;
  logic [AW-1:0]     last_word_r, last_word_nxt;
  logic [WORD_AW:0]  tail_r, tail_nxt;
  logic [PW-1:0]     lo_r, lo_nxt;
  logic [PW-1:0]     hi_r, hi_nxt;
  logic              res_granted_r, res_granted_nxt;
  logic [PW-1:0]     res_start_r, res_start_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_granted_r;
  logic [SLOT_W-1:0] out_start_r;
  logic [REJ_W-1:0]  out_rej_r;
  logic              out_load;

  logic              accept;
  logic [LIM_W-1:0]  lim;
  logic [LIM_W-1:0]  lim_m1;
  logic [AW-1:0]     lo_word;
  logic [AW-1:0]     hi_word;
  logic [PW-1:0]     found_pos;
  logic [XW-1:0]     start_x;
  logic [PW-1:0]     found_start;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  word_t             ram_wdata;
  word_t             ram_rdata;
  word_t             unit_wdata;
  logic [WORD_AW:0]  unit_nvalid;
  wr_ctl_t           wctl;
  scan_res_t         scan_res;

  ffca_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_addr_r[AW-1:0]),
    .rdata(ram_rdata)
  );

  ffca_word_unit u_unit (
    .word  (ram_rdata),
    .nvalid(unit_nvalid),
    .carry (carry_r),
    .count (cnt_r),
    .wctl  (wctl),
    .res   (scan_res),
    .wdata (unit_wdata)
  );

  assign in_stall           = (state_r != ST_IDLE);
  assign accept             = in_valid && !in_stall;
  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_granted        = out_granted_r;
  assign out_start_slot     = out_start_r;
  assign out_rejected_total = out_rej_r;

  always_comb begin
    if (LIM_W'(cfg_r) > LIM_W'(SLOTS)) begin
      lim = LIM_W'(SLOTS);
    end else begin
      lim = LIM_W'(cfg_r);
    end
    lim_m1 = lim - LIM_W'(1);
  end

  assign lo_word     = lo_r[PW-1:WORD_AW];
  assign hi_word     = hi_r[PW-1:WORD_AW];
  assign found_pos   = {pend_addr_r, scan_res.offset};
  assign start_x     = XW'(found_pos) + XW'(1) - XW'(cnt_r);
  assign found_start = start_x[PW-1:0];
  assign unit_nvalid = (pend_addr_r == last_word_r) ? tail_r : (WORD_AW+1)'(WORD_W);
  assign ram_wdata   = (state_r == ST_CLEAR) ? '0 : unit_wdata;

  always_comb begin
    wctl.set = (state_r == ST_MARK);
    wctl.lo  = (pend_addr_r == lo_word) ? lo_r[WORD_AW-1:0] : '0;
    wctl.hi  = (pend_addr_r == hi_word) ? hi_r[WORD_AW-1:0] : '1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cfg_r       <= cnt_t'(1024);
      rej_r       <= '0;
      rd_addr_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rej_r       <= rej_nxt;
      rd_addr_r   <= rd_addr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cfg_r <= cfg_slots_in_use;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r         <= cnt_nxt;
    pend_addr_r   <= pend_addr_nxt;
    carry_r       <= carry_nxt;
    last_word_r   <= last_word_nxt;
    tail_r        <= tail_nxt;
    lo_r          <= lo_nxt;
    hi_r          <= hi_nxt;
    res_granted_r <= res_granted_nxt;
    res_start_r   <= res_start_nxt;
    if (out_load) begin
      out_granted_r <= res_granted_r;
      out_start_r   <= SLOT_W'(res_start_r);
      out_rej_r     <= rej_r;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    rej_nxt         = rej_r;
    cnt_nxt         = cnt_r;
    rd_addr_nxt     = rd_addr_r;
    pend_nxt        = 1'b0;
    pend_addr_nxt   = pend_addr_r;
    carry_nxt       = carry_r;
    last_word_nxt   = last_word_r;
    tail_nxt        = tail_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    res_granted_nxt = res_granted_r;
    res_start_nxt   = res_start_r;
    ram_we          = 1'b0;
    ram_waddr       = pend_addr_r;
    out_load        = 1'b0;
    out_valid_nxt   = out_valid_r && out_stall;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = rd_addr_r[AW-1:0];
        if (rd_addr_r == (AW+1)'(DEPTH - 1)) begin
          rd_addr_nxt = '0;
          state_nxt   = ST_IDLE;
        end else begin
          rd_addr_nxt = rd_addr_r + (AW+1)'(1);
        end
      end

      ST_IDLE: begin
        if (accept) begin
          cnt_nxt         = in_count;
          carry_nxt       = '0;
          last_word_nxt   = AW'(lim_m1 >> WORD_AW);
          tail_nxt        = {1'b0, lim_m1[WORD_AW-1:0]} + (WORD_AW+1)'(1);
          res_granted_nxt = 1'b1;
          res_start_nxt   = '0;
          rd_addr_nxt     = '0;
          if (in_operation == OP_ALLOC) begin
            if (in_count == '0) begin
              state_nxt = ST_DONE;
            end else if (LIM_W'(in_count) > lim) begin
              res_granted_nxt = 1'b0;
              if (rej_r != '1) begin
                rej_nxt = rej_r + REJ_W'(1);
              end
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_SCAN;
            end
          end else begin
            if (in_last_slot < in_first_slot || 32'(in_first_slot) >= SLOTS) begin
              state_nxt = ST_DONE;
            end else begin
              lo_nxt = PW'(in_first_slot);
              if (32'(in_last_slot) >= SLOTS) begin
                hi_nxt = PW'(SLOTS - 1);
              end else begin
                hi_nxt = PW'(in_last_slot);
              end
              rd_addr_nxt = {1'b0, lo_nxt[PW-1:WORD_AW]};
              state_nxt   = ST_FREE;
            end
          end
        end
      end

      ST_SCAN: begin
        if (rd_addr_r <= {1'b0, last_word_r}) begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = rd_addr_r[AW-1:0];
          rd_addr_nxt   = rd_addr_r + (AW+1)'(1);
        end
        if (pend_r) begin
          if (scan_res.found) begin
            lo_nxt        = found_start;
            hi_nxt        = found_pos;
            res_start_nxt = found_start;
            pend_nxt      = 1'b0;
            pend_addr_nxt = pend_addr_r;
            rd_addr_nxt   = {1'b0, found_start[PW-1:WORD_AW]};
            state_nxt     = ST_MARK;
          end else if (pend_addr_r == last_word_r) begin
            res_granted_nxt = 1'b0;
            res_start_nxt   = '0;
            if (rej_r != '1) begin
              rej_nxt = rej_r + REJ_W'(1);
            end
            pend_nxt  = 1'b0;
            state_nxt = ST_DONE;
          end else begin
            carry_nxt = scan_res.carry;
          end
        end
      end

      ST_MARK, ST_FREE: begin
        if (rd_addr_r <= {1'b0, hi_word}) begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = rd_addr_r[AW-1:0];
          rd_addr_nxt   = rd_addr_r + (AW+1)'(1);
        end
        if (pend_r) begin
          ram_we = 1'b1;
          if (pend_addr_r == hi_word) begin
            pend_nxt  = 1'b0;
            state_nxt = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_refusal_has_zero_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_granted_r |-> out_start_r == '0)
    else $error("refused word carries a start slot");

  a_no_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r != ST_IDLE && state_r != ST_DONE)
    else $error("map written outside a clear or range pass");

  a_scan_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN && pend_r |-> pend_addr_r <= last_word_r)
    else $error("scan ran past the usable row");

  a_counter_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_CLEAR |=> rej_r >= $past(rej_r))
    else $error("rejection total went down");

  a_load_only_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && state_r == ST_IDLE)
    else $error("output load did not complete the item");

endmodule

FILE: tb/ffca_check_pkg.sv
// Grant predictor and result checker for the first-fit allocator testbench.
`timescale 1ns / 1ps
package ffca_check_pkg;
  import ffca_pkg::*;

  localparam int MAP_SLOTS = 1024;
  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic              granted;
    logic [SLOT_W-1:0] start;
    logic [REJ_W-1:0]  rejected;
  } grant_t;

  class grant_checker;
    bit [MAP_SLOTS-1:0] taken_map;
    logic [REJ_W-1:0]   refusals;
    cnt_t               row_limit;
    grant_t             due_grants[$];
    int                 errors;

    function new();
      taken_map = '0;
      refusals  = '0;
      row_limit = cnt_t'(MAP_SLOTS);
      errors    = 0;
    endfunction

    function grant_t predict_grant(logic op, cnt_t cnt, logic [SLOT_W-1:0] fs,
                                   logic [SLOT_W-1:0] ls);
      grant_t g;
      int     lim;
      int     run;
      int     st;
      bit     found;
      g.granted = 1'b1;
      st = 0;
      run = 0;
      found = 1'b0;
      if (op == OP_ALLOC) begin
        lim = (row_limit > MAP_SLOTS) ? MAP_SLOTS : int'(row_limit);
        if (cnt == 0) begin
          found = 1'b1;
        end else if (cnt <= lim) begin
          for (int i = 0; i < lim && !found; i++) begin
            if (taken_map[i]) begin
              run = 0;
            end else begin
              run++;
              if (run == cnt) begin
                st = i + 1 - int'(cnt);
                found = 1'b1;
              end
            end
          end
          if (found) begin
            for (int k = st; k < st + int'(cnt); k++) taken_map[k] = 1'b1;
          end
        end
        if (!found) begin
          g.granted = 1'b0;
          st = 0;
          if (refusals != '1) refusals++;
        end
      end else if (ls >= fs) begin
        for (int k = fs; k <= ls; k++) taken_map[k] = 1'b0;
      end
      g.start = st[SLOT_W-1:0];
      g.rejected = refusals;
      return g;
    endfunction

    function void note_request(logic op, cnt_t cnt, logic [SLOT_W-1:0] fs,
                               logic [SLOT_W-1:0] ls);
      due_grants.push_back(predict_grant(op, cnt, fs, ls));
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= PRINT_CAP) $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task check_grant(logic g, logic [SLOT_W-1:0] s, logic [REJ_W-1:0] r);
      grant_t want;
      if (due_grants.size() == 0) begin
        report_mismatch($sformatf("unexpected result word g=%0d s=%0d r=%0d", g, s, r));
      end else begin
        want = due_grants.pop_front();
        if (g !== want.granted)
          report_mismatch($sformatf("granted %0d, want %0d", g, want.granted));
        if (s !== want.start)
          report_mismatch($sformatf("start_slot %0d, want %0d", s, want.start));
        if (r !== want.rejected)
          report_mismatch($sformatf("rejected_total %0d, want %0d", r, want.rejected));
      end
    endtask
  endclass

endpackage

FILE: tb/first_fit_contiguous_allocator_core_test.sv
// Top-level testbench for the first-fit contiguous allocator core.
`timescale 1ns / 1ps
module first_fit_contiguous_allocator_core_test;
  import ffca_pkg::*;
  import ffca_check_pkg::*;

  localparam int REFUSE_BURST = 40;
  localparam int HOLD_LEN     = 300;
  localparam int TAIL_WAIT    = 100;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_operation;
  logic [CNT_W-1:0]  in_count;
  logic [SLOT_W-1:0] in_first_slot;
  logic [SLOT_W-1:0] in_last_slot;
  logic              out_valid;
  logic              out_stall;
  logic              out_granted;
  logic [SLOT_W-1:0] out_start_slot;
  logic [REJ_W-1:0]  out_rejected_total;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_slots_in_use;

  bit in_quiet;
  bit out_quiet;

  grant_checker ledger = new();

  first_fit_contiguous_allocator_core #(.SLOTS(MAP_SLOTS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_operation(in_operation),
    .in_count(in_count),
    .in_first_slot(in_first_slot),
    .in_last_slot(in_last_slot),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_granted(out_granted),
    .out_start_slot(out_start_slot),
    .out_rejected_total(out_rejected_total),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_slots_in_use(cfg_slots_in_use)
  );

  always #10 clk = ~clk;

  task automatic send_item(logic op, cnt_t cnt, logic [SLOT_W-1:0] fs,
                           logic [SLOT_W-1:0] ls);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(6, 0);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_count      <= cnt;
    in_first_slot <= fs;
    in_last_slot  <= ls;
    do @(posedge clk); while (in_stall);
    ledger.note_request(op, cnt, fs, ls);
  endtask

  task automatic alloc(cnt_t cnt);
    send_item(OP_ALLOC, cnt, SLOT_W'($urandom), SLOT_W'($urandom));
  endtask

  task automatic free_range(int fs, int ls);
    send_item(OP_RELEASE, CNT_W'($urandom), SLOT_W'(fs), SLOT_W'(ls));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (ledger.due_grants.size() != 0) @(posedge clk);
  endtask

  task automatic write_row(int rows);
    @(negedge clk);
    cfg_valid        <= 1'b1;
    cfg_slots_in_use <= CNT_W'(rows);
    do @(posedge clk); while (!cfg_ready);
    ledger.row_limit = CNT_W'(rows);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly small allocs and local frees so the map fragments and refills
  task automatic random_item();
    int pick;
    int span;
    int base;
    int fs;
    pick = $urandom_range(99, 0);
    span = (ledger.row_limit > MAP_SLOTS) ? MAP_SLOTS : int'(ledger.row_limit);
    if (span < 1) span = 1;
    if (pick < 36) begin
      alloc(CNT_W'($urandom_range(16, 1)));
    end else if (pick < 46) begin
      alloc(CNT_W'($urandom_range(span, 1)));
    end else if (pick < 52) begin
      alloc(CNT_W'($urandom_range(2047, 0)));
    end else if (pick < 94) begin
      base = $urandom_range(span - 1, 0);
      fs = base + $urandom_range(23, 0);
      free_range(base, (fs > MAP_SLOTS - 1) ? MAP_SLOTS - 1 : fs);
    end else if (pick < 97) begin
      fs = $urandom_range(MAP_SLOTS - 1, 1);
      free_range(fs, $urandom_range(fs - 1, 0));
    end else begin
      fs = $urandom_range(MAP_SLOTS - 1, 0);
      free_range(fs, $urandom_range(MAP_SLOTS - 1, fs));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      ledger.check_grant(out_granted, out_start_slot, out_rejected_total);
  end

  initial begin : result_taker
    int gap;
    int taken;
    out_stall = 1'b0;
    taken = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = out_quiet ? 0 : $urandom_range(6, 0);
      if (taken == 50 || taken == 900) gap = HOLD_LEN;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin : stimulus
    int rows[8];
    rows = '{1024, 1, 0, 2047, 37, 300, 1000, 1024};
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_operation     = OP_ALLOC;
    in_count         = '0;
    in_first_slot    = '0;
    in_last_slot     = '0;
    cfg_valid        = 1'b0;
    cfg_slots_in_use = '0;
    in_quiet         = 1'b0;
    out_quiet        = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    alloc(0);
    alloc(1);
    alloc(2047);
    alloc(1025);
    alloc(1023);
    alloc(1);
    free_range(0, 1023);
    alloc(1024);
    free_range(5, 3);
    alloc(1);
    free_range(512, 512);
    alloc(2);
    alloc(1);
    free_range(1023, 1023);
    free_range(0, 0);
    alloc(1);
    alloc(1);
    free_range(100, 199);
    free_range(300, 349);
    alloc(60);
    alloc(50);
    alloc(40);
    free_range(0, 1023);
    alloc(0);

    foreach (rows[p]) begin
      drain();
      write_row(rows[p]);
      in_quiet  = ($urandom_range(3, 0) == 0);
      out_quiet = ($urandom_range(3, 0) == 0);
      repeat (148) random_item();
    end

    // short burst of refusals on an empty row with no idling
    drain();
    write_row(0);
    in_quiet  = 1'b1;
    out_quiet = 1'b1;
    alloc(0);
    repeat (REFUSE_BURST) alloc(CNT_W'($urandom_range(2047, 1)));
    alloc(0);
    drain();
    write_row(1024);
    in_quiet  = 1'b0;
    out_quiet = 1'b0;
    alloc(2047);
    alloc(8);
    free_range(0, 1023);
    alloc(2047);

    drain();
    repeat (TAIL_WAIT) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #60_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: first_fit_contiguous_allocator_core.f
hdl/ffca_pkg.sv
hdl/ffca_ram.sv
hdl/ffca_word_unit.sv
hdl/first_fit_contiguous_allocator_core.sv
tb/ffca_check_pkg.sv
tb/first_fit_contiguous_allocator_core_test.sv
